### rtl/core/rpp_pkg.sv
`default_nettype none

package rpp_pkg;

  // Panel geometry: twelve native columns per group, packed into three bytes
  localparam int GroupCols     = 12;
  localparam int BytesPerGroup = 3;
  localparam int PixelsPerByte = 4;

  // Item kinds on the command channel
  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_PACK  = 1'b1
  } mode_t;

  // Tag carried alongside each canvas read through the read latency
  typedef struct packed {
    logic       rej;    // request failed its range checks, no read behind it
    logic       white;  // column lies outside the canvas, pixel pair is white
    logic [3:0] slot;   // column within the group, 0..11
    logic [1:0] sel;    // pixel pair position inside the canvas byte
  } slot_tag_t;

endpackage

`default_nettype wire

### rtl/core/rpp_ram.sv
`default_nettype none

module rpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/rotated_panel_row_packer.sv
`default_nettype none

// Rotated panel row packer.
// One command channel: an item is taken when start is high and busy is low.
// mode 0 writes canvas_data to canvas byte canvas_address (addresses beyond
// the canvas are dropped) and returns nothing.
// mode 1 packs panel row first_row + row_offset, column group group, into
// three bytes. The canvas lives in a byte-wide RAM with one read port, and a
// group needs twelve canvas rows, so a pack holds the read port while it reads
// them in turn: busy stays high until the last read issues, so the next item
// can be taken while the bytes of the pack are still in flight. Bytes 0, 1
// and 2 follow in order, one cycle each with strobe high; last marks byte 2.
// A request failing its range checks returns one result, with rejected and
// last set, and frees the channel in the cycle after the transfer.
// Results are never stalled: the receiver takes each one the cycle it shows.
// Reset clears the sequencing state; the canvas itself is not cleared and must
// be written before it is packed.
module rotated_panel_row_packer #(
  parameter int HEIGHT        = 300,
  parameter int PACKED_ROWS   = 200,
  parameter int COLUMN_GROUPS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [13:0] canvas_address,
  input  logic [7:0]  canvas_data,
  input  logic [7:0]  first_row,
  input  logic [7:0]  row_count,
  input  logic [7:0]  row_offset,
  input  logic [4:0]  group,
  output logic        strobe,
  output logic [7:0]  packed_byte,
  output logic [1:0]  byte_index,
  output logic        last,
  output logic        rejected
);

  localparam int Stride     = (PACKED_ROWS * 2 + 7) / 8;
  localparam int StoreDepth = HEIGHT * Stride;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int ColW       = $clog2(rpp_pkg::GroupCols * COLUMN_GROUPS + 1);
  localparam logic [3:0] LastSlot = 4'(rpp_pkg::GroupCols - 1);

  // Issue stage: one canvas read per cycle
  logic                 act;
  logic                 iss_rej;
  logic [3:0]           cnt;
  logic [ColW-1:0]      col;
  logic [AddrW-1:0]     addr;
  logic [1:0]           sel;

  // Read data stage
  logic                 s2_val;
  rpp_pkg::slot_tag_t   tag;
  logic [7:0]           rdata;
  logic [5:0]           acc;
  logic [1:0]           pair;

  logic                 accept;
  logic                 pack_accept;
  logic                 write_en;
  logic                 req_ok;
  logic                 last_issue;
  logic                 white_now;
  logic                 re;
  logic [8:0]           row;
  logic [31:0]          start_addr;
  logic [ColW-1:0]      start_col;

  // Handshake
  assign last_issue  = act && (iss_rej || cnt == LastSlot);
  assign busy        = act && !last_issue;
  assign accept      = start && !busy;
  assign pack_accept = accept && (mode == rpp_pkg::MODE_PACK);
  assign write_en    = accept && (mode == rpp_pkg::MODE_WRITE) &&
                       (32'(canvas_address) < StoreDepth);

  // Range checks on a pack request
  assign req_ok = (row_count != 8'd0) &&
                  (32'(first_row) + 32'(row_count) <= PACKED_ROWS) &&
                  (row_offset < row_count) &&
                  (32'(group) < COLUMN_GROUPS);

  // Start at canvas row HEIGHT-1-12g, byte holding columns 2r and 2r+1
  assign row        = 9'(first_row) + 9'(row_offset);
  assign start_addr = 32'((HEIGHT - 1) * Stride)
                    - 32'(group) * 32'(rpp_pkg::GroupCols * Stride)
                    + 32'(row[8:2]);
  assign start_col  = ColW'(32'(group) * 32'(rpp_pkg::GroupCols));

  // Columns past the canvas read as white and skip the RAM
  assign white_now = 32'(col) >= HEIGHT;
  assign re        = act && !iss_rej && !white_now;

  // Keep the issue stage active from acceptance until its last read issues
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
    end else if (pack_accept) begin
      act <= 1'b1;
    end else if (last_issue) begin
      act <= 1'b0;
    end
  end

  // Advance one canvas row per cycle, upwards through the landscape image
  always_ff @(posedge clk) begin
    if (pack_accept) begin
      iss_rej <= !req_ok;
      cnt     <= 4'd0;
      col     <= start_col;
      addr    <= AddrW'(start_addr);
      sel     <= row[1:0];
    end else if (act) begin
      cnt <= cnt + 4'd1;
      col <= col + ColW'(1);
      if (!white_now) begin
        addr <= addr - AddrW'(Stride);
      end
    end
  end

  rpp_ram #(
    .WIDTH (8),
    .DEPTH (StoreDepth)
  ) u_canvas (
    .clk   (clk),
    .we    (write_en),
    .waddr (AddrW'(canvas_address)),
    .wdata (canvas_data),
    .re    (re),
    .raddr (addr),
    .rdata (rdata)
  );

  // Track the tag across the read latency
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_val <= 1'b0;
    end else begin
      s2_val <= act;
    end
  end

  always_ff @(posedge clk) begin
    tag.rej   <= iss_rej;
    tag.white <= white_now;
    tag.slot  <= cnt;
    tag.sel   <= sel;
  end

  // Pick the even/odd pixel pair out of the canvas byte
  assign pair = tag.white ? 2'b11 : 2'(rdata >> {~tag.sel, 1'b0});

  // Shift pairs in, first column at the top
  always_ff @(posedge clk) begin
    if (s2_val && !tag.rej) begin
      acc <= {acc[3:0], pair};
    end
  end

  // Result register: one transfer per completed byte or per rejection
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= s2_val &&
                (tag.rej || tag.slot[1:0] == 2'(rpp_pkg::PixelsPerByte - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (tag.rej) begin
      packed_byte <= 8'd0;
      byte_index  <= 2'd0;
      last        <= 1'b1;
      rejected    <= 1'b1;
    end else begin
      packed_byte <= {acc, pair};
      byte_index  <= tag.slot[3:2];
      last        <= tag.slot[3:2] == 2'(rpp_pkg::BytesPerGroup - 1);
      rejected    <= 1'b0;
    end
  end

  // A rejected request answers after the fixed short latency
  a_reject_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == rpp_pkg::MODE_PACK && !req_ok)
      |-> ##3 (strobe && rejected && last))
    else $error("rejected request did not answer on time");

  // A valid request delivers byte 0 as its first result, not marked last
  a_first_byte: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == rpp_pkg::MODE_PACK && req_ok)
      |-> ##6 (strobe && !rejected && byte_index == 2'd0 && !last))
    else $error("first packed byte missing");

  // It also delivers its final byte, byte 2, marked last
  a_final_byte: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == rpp_pkg::MODE_PACK && req_ok)
      |-> ##14 (strobe && !rejected && byte_index == 2'd2 && last))
    else $error("final packed byte missing");

endmodule

`default_nettype wire

### dv/rpp_checker.sv
`timescale 1ns / 1ps

// Watches the command and result channels of the row packer, keeps its own
// copy of the canvas, predicts the panel bytes of each pack request and
// compares every strobed result with the oldest outstanding prediction.
module rpp_checker #(
  parameter int HEIGHT        = 300,
  parameter int PACKED_ROWS   = 200,
  parameter int COLUMN_GROUPS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        mode,
  input  logic [13:0] canvas_address,
  input  logic [7:0]  canvas_data,
  input  logic [7:0]  first_row,
  input  logic [7:0]  row_count,
  input  logic [7:0]  row_offset,
  input  logic [4:0]  group,
  input  logic        strobe,
  input  logic [7:0]  packed_byte,
  input  logic [1:0]  byte_index,
  input  logic        last,
  input  logic        rejected,
  output int          fails,
  output int          outstanding,
  output int          checked
);

  localparam int Stride = (PACKED_ROWS * 2 + 7) / 8;
  localparam int Depth  = HEIGHT * Stride;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] pos;
    logic       last_flag;
    logic       rej_flag;
  } panel_byte_t;

  logic [7:0]  canvas_copy [Depth];
  panel_byte_t panel_bytes_due [$];
  int          fail_count = 0;
  int          byte_count = 0;

  // Canvas pixel at landscape column x, row y; off-canvas reads white
  function automatic logic canvas_pixel(int x, int y);
    int addr;
    if (y < 0 || y >= HEIGHT) return 1'b1;
    addr = y * Stride + x / 8;
    if (addr >= Depth) return 1'b1;
    return canvas_copy[addr][7 - (x % 8)];
  endfunction

  // Queue the panel bytes that one pack request must produce
  task automatic predict_panel_bytes(int f, int c, int o, int g);
    int          row;
    int          col;
    logic [7:0]  v;
    panel_byte_t pb;
    if (c == 0 || f + c > PACKED_ROWS || o >= c || g >= COLUMN_GROUPS) begin
      pb.value     = 8'h00;
      pb.pos       = 2'd0;
      pb.last_flag = 1'b1;
      pb.rej_flag  = 1'b1;
      panel_bytes_due.push_back(pb);
      return;
    end
    row = f + o;
    for (int b = 0; b < rpp_pkg::BytesPerGroup; b++) begin
      v = '0;
      for (int k = 0; k < rpp_pkg::PixelsPerByte; k++) begin
        col = g * rpp_pkg::GroupCols + b * rpp_pkg::PixelsPerByte + k;
        v[7 - 2 * k] = canvas_pixel(2 * row, HEIGHT - 1 - col);
        v[6 - 2 * k] = canvas_pixel(2 * row + 1, HEIGHT - 1 - col);
      end
      pb.value     = v;
      pb.pos       = 2'(b);
      pb.last_flag = (b == rpp_pkg::BytesPerGroup - 1);
      pb.rej_flag  = 1'b0;
      panel_bytes_due.push_back(pb);
    end
  endtask

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    panel_byte_t want;
    if (rst) begin
      panel_bytes_due.delete();
      fail_count = 0;
      byte_count = 0;
    end else begin
      // match each strobed result against the oldest prediction
      if (strobe) begin
        if (panel_bytes_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h/%0d/%0b/%0b",
                   $time, packed_byte, byte_index, last, rejected);
          fail_count++;
        end else begin
          want = panel_bytes_due.pop_front();
          compare_field("packed_byte", want.value, packed_byte);
          compare_field("byte_index", 8'(want.pos), 8'(byte_index));
          compare_field("last", 8'(want.last_flag), 8'(last));
          compare_field("rejected", 8'(want.rej_flag), 8'(rejected));
          byte_count++;
        end
      end
      // apply each command transfer to the canvas copy or the prediction queue
      if (start && !busy) begin
        if (mode == rpp_pkg::MODE_WRITE) begin
          if (canvas_address < Depth) canvas_copy[canvas_address] = canvas_data;
        end else begin
          predict_panel_bytes(first_row, row_count, row_offset, group);
        end
      end
    end
    fails       <= fail_count;
    outstanding <= panel_bytes_due.size();
    checked     <= byte_count;
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int Height        = 300;
  localparam int PackedRows    = 200;
  localparam int ColumnGroups  = 25;
  localparam int Stride        = (PackedRows * 2 + 7) / 8;
  localparam int Depth         = Height * Stride;
  localparam int TotalItems    = 500;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        mode = rpp_pkg::MODE_WRITE;
  logic [13:0] canvas_address = '0;
  logic [7:0]  canvas_data = '0;
  logic [7:0]  first_row = '0;
  logic [7:0]  row_count = '0;
  logic [7:0]  row_offset = '0;
  logic [4:0]  group = '0;
  logic        busy;
  logic        strobe;
  logic [7:0]  packed_byte;
  logic [1:0]  byte_index;
  logic        last;
  logic        rejected;
  int          fails;
  int          outstanding;
  int          checked;

  bit          canvas_written [Depth];
  int          idle_pct = 0;
  int          quiet_cycles = 0;
  int          items_sent = 0;
  int          packs_sent = 0;
  int          rejects_sent = 0;
  int          writes_sent = 0;
  int          writes_dropped = 0;
  int          last_row = 0;
  int          last_grp = 0;
  int          phase_idle [4] = '{0, 49, 31, 0};

  always #5 clk = ~clk;

  rotated_panel_row_packer #(
    .HEIGHT(Height), .PACKED_ROWS(PackedRows), .COLUMN_GROUPS(ColumnGroups)
  ) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .canvas_address(canvas_address), .canvas_data(canvas_data),
    .first_row(first_row), .row_count(row_count), .row_offset(row_offset),
    .group(group), .strobe(strobe), .packed_byte(packed_byte),
    .byte_index(byte_index), .last(last), .rejected(rejected)
  );

  rpp_checker #(
    .HEIGHT(Height), .PACKED_ROWS(PackedRows), .COLUMN_GROUPS(ColumnGroups)
  ) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .canvas_address(canvas_address), .canvas_data(canvas_data),
    .first_row(first_row), .row_count(row_count), .row_offset(row_offset),
    .group(group), .strobe(strobe), .packed_byte(packed_byte),
    .byte_index(byte_index), .last(last), .rejected(rejected),
    .fails(fails), .outstanding(outstanding), .checked(checked)
  );

  // Drive one command and hold it until the transfer; start is left high
  task automatic transfer(logic m, logic [13:0] a, logic [7:0] d, int f, int c, int o, int g);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    mode           <= m;
    canvas_address <= a;
    canvas_data    <= d;
    first_row      <= 8'(f);
    row_count      <= 8'(c);
    row_offset     <= 8'(o);
    group          <= 5'(g);
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Canvas write with noise on the unused pack fields
  task automatic write_canvas(int a, logic [7:0] d);
    transfer(rpp_pkg::MODE_WRITE, 14'(a), d, $urandom_range(255), $urandom_range(255),
             $urandom_range(255), $urandom_range(31));
    if (a < Depth) begin
      canvas_written[a] = 1'b1;
      writes_sent++;
    end else begin
      writes_dropped++;
    end
  endtask

  // Pack request; fill any canvas byte it reads that was never written
  task automatic request_pack(int f, int c, int o, int g);
    int row;
    int y;
    int addr;
    if (c != 0 && f + c <= PackedRows && o < c && g < ColumnGroups) begin
      row = f + o;
      for (int col = g * rpp_pkg::GroupCols; col < (g + 1) * rpp_pkg::GroupCols; col++) begin
        y = Height - 1 - col;
        if (y >= 0 && y < Height) begin
          addr = y * Stride + (2 * row) / 8;
          if (!canvas_written[addr]) write_canvas(addr, 8'($urandom));
        end
      end
      packs_sent++;
      last_row = row;
      last_grp = g;
    end else begin
      rejects_sent++;
    end
    transfer(rpp_pkg::MODE_PACK, 14'($urandom), 8'($urandom), f, c, o, g);
  endtask

  // One random stimulus action, mostly well-formed pack requests
  task automatic random_action();
    int sel;
    int row;
    int f;
    int c;
    int o;
    int g;
    int col;
    sel = $urandom_range(99);
    if (sel < 55) begin
      if ($urandom_range(1)) row = (last_row & ~3) | $urandom_range(3);
      else row = $urandom_range(PackedRows - 1);
      f = $urandom_range(row);
      o = row - f;
      c = $urandom_range(PackedRows - f, o + 1);
      request_pack(f, c, o, $urandom_range(ColumnGroups - 1));
    end else if (sel < 65) begin
      // rewrite one canvas byte read by the last packed group, then pack it again
      col = last_grp * rpp_pkg::GroupCols + $urandom_range(rpp_pkg::GroupCols - 1);
      write_canvas((Height - 1 - col) * Stride + (2 * last_row) / 8, 8'($urandom));
      request_pack(last_row, 1, 0, last_grp);
    end else if (sel < 80) begin
      write_canvas($urandom_range(16383), 8'($urandom));
    end else if (sel < 92) begin
      case ($urandom_range(3))
        0: request_pack($urandom_range(255), 0, $urandom_range(255), $urandom_range(31));
        1: begin
          f = $urandom_range(255);
          c = $urandom_range(255, 1);
          if (f + c <= PackedRows) c = PackedRows + 1 - f;
          request_pack(f, c, $urandom_range(c - 1), $urandom_range(ColumnGroups - 1));
        end
        2: begin
          c = $urandom_range(PackedRows, 1);
          request_pack($urandom_range(PackedRows - c), c, $urandom_range(255, c),
                       $urandom_range(ColumnGroups - 1));
        end
        default: begin
          c = $urandom_range(PackedRows, 1);
          request_pack($urandom_range(PackedRows - c), c, $urandom_range(c - 1),
                       $urandom_range(31, ColumnGroups));
        end
      endcase
    end else begin
      request_pack($urandom_range(255), $urandom_range(255), $urandom_range(255),
                   $urandom_range(31));
    end
  endtask

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time, outstanding);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: canvas address extremes and dropped writes
    write_canvas(Depth - 1, 8'hFF);
    write_canvas(Depth, 8'h5A);
    write_canvas(16383, 8'hFF);
    write_canvas(0, 8'h00);
    // directed: first and last panel rows, bottom and top groups
    request_pack(0, PackedRows, 0, ColumnGroups - 1);
    request_pack(0, 4, 3, ColumnGroups - 1);
    request_pack(PackedRows - 1, 1, 0, 0);
    // directed: each kind of rejected request
    request_pack(0, 0, 0, 0);
    request_pack(PackedRows - 1, 2, 0, 0);
    request_pack(0, 5, 5, 0);
    request_pack(0, 1, 0, ColumnGroups);
    request_pack(255, 255, 255, 31);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      while (items_sent < (phase + 1) * (TotalItems / 4)) random_action();
      // hold off until every expected byte has come
      start <= 1'b0;
      @(posedge clk);
      while (outstanding != 0) @(posedge clk);
    end

    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d packs, %0d rejected requests, %0d writes, %0d dropped writes",
             packs_sent, rejects_sent, writes_sent, writes_dropped);
    $display("%0d result bytes over %0d transfers, sender idle 0, 31 and 49 percent",
             checked, items_sent);
    if (fails == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fails, outstanding);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/rpp_pkg.sv
rtl/core/rpp_ram.sv
rtl/core/rotated_panel_row_packer.sv
dv/rpp_checker.sv
dv/tb_top.sv
